// ----- rtl/core/rita_pkg.sv -----
// shared constants and helpers of the radix integer to ascii unit
`default_nettype none

package rita_pkg;

    // default sizes
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    // fixed field widths
    localparam int RADIX_BITS       = 5;
    localparam int WIDTH_FIELD_BITS = 6;
    localparam int CHAR_BITS        = 8;
    localparam int DIGIT_BITS       = 4;

    // supported bases
    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

    // character codes
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 8'h00;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 4'ha;

    // digit value to lowercase ascii
    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ext;
        ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + ext;
        end else begin
            return CHAR_A + (ext - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DIGIT_TEN});
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rita_if.sv -----
// request and character channel interfaces of the radix integer to ascii unit
`default_nettype none

interface rita_req_if #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic [VALUE_BITS-1:0]                 number;
    logic                                  is_signed;
    logic [rita_pkg::RADIX_BITS-1:0]       radix;
    logic [rita_pkg::WIDTH_FIELD_BITS-1:0] min_width;

    modport source (output valid, number, is_signed, radix, min_width, input ready);
    modport sink   (input valid, number, is_signed, radix, min_width, output ready);
endinterface

interface rita_chr_if;
    logic                           valid;
    logic                           ready;
    logic [rita_pkg::CHAR_BITS-1:0] character;
    logic                           char_valid;
    logic                           last;

    modport source (output valid, character, char_valid, last, input ready);
    modport sink   (input valid, character, char_valid, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/radix_integer_to_ascii_unit.sv -----
// top level: converts an integer request into a stream of ascii characters
//
// usage
//  - i_req carries one request: number, is_signed, radix (2..16, clamped) and
//    min_width (0..63, clamped to MAX_DIGITS); ready is high only while idle
//  - o_chr carries the characters, most significant digit first, a leading
//    minus for a negative signed number, last set on the final character;
//    zero with width zero gives one result with char_valid low and last high
//  - the request is taken, then one division pass over the VALUE_BITS bits
//    runs for each significant digit (one restoring division step per cycle
//    through the value shift register), then one character per cycle when
//    not stalled
//  - the next request may be taken while the final character still waits in
//    the output register
//  - a stalled receiver holds the output register and stops the emit walk
//  - reset is synchronous, active low, and returns to idle with no output
//    pending; the digit store is not cleared, it is always written before use
`default_nettype none

module radix_integer_to_ascii_unit #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rita_pkg::MAX_DIGITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rita_req_if.sink    i_req,
    rita_chr_if.source  o_chr
);

    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);      // digit counts up to MAX_DIGITS
    localparam int IDX_W   = $clog2(MAX_DIGITS);          // digit store address
    localparam int BIT_W   = $clog2(VALUE_BITS);          // bit position within a pass
    localparam int CLAMP_W = rita_pkg::WIDTH_FIELD_BITS + 1;
    localparam int DB      = rita_pkg::DIGIT_BITS;
    localparam int RB      = rita_pkg::RADIX_BITS;
    localparam int CB      = rita_pkg::CHAR_BITS;

    localparam logic [BIT_W-1:0]   LAST_BIT   = BIT_W'(VALUE_BITS - 1);
    localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_DIGITS);
    localparam logic [CLAMP_W-1:0] MAX_CLAMP  = CLAMP_W'(MAX_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // control
    t_state              r_state,      n_state;
    logic                r_out_valid,  n_out_valid;
    // datapath
    logic [VALUE_BITS-1:0] r_value,    n_value;     // dividend shifting out, quotient shifting in
    logic [DB-1:0]       r_rem,        n_rem;       // partial remainder, always below radix
    logic [BIT_W-1:0]    r_bit_cnt,    n_bit_cnt;
    logic [CNT_W-1:0]    r_count,      n_count;     // significant digits found
    logic [CNT_W-1:0]    r_width,      n_width;     // clamped minimum width
    logic [CNT_W-1:0]    r_pos,        n_pos;       // digit position still to emit
    logic [RB-1:0]       r_radix,      n_radix;
    logic                r_sign,       n_sign;      // minus still to emit
    logic                r_empty,      n_empty;     // zero with width zero
    logic [CB-1:0]       r_char,       n_char;
    logic                r_char_valid, n_char_valid;
    logic                r_last,       n_last;

    // digit store, least significant digit first
    logic [DB-1:0]       r_digit_store [MAX_DIGITS];
    // stored digit at the current emit position
    logic [DB-1:0]       r_emit_digit;
    logic [IDX_W-1:0]    rd_addr;

    // one restoring division step
    logic [DB:0]         trial;
    logic                quo_bit;
    logic [DB-1:0]       rem_next;
    logic                store_we;

    // request decode
    logic                req_neg;
    logic [VALUE_BITS-1:0] req_mag;
    logic [CLAMP_W-1:0]  width_ext;
    logic [CLAMP_W-1:0]  width_clamp;

    // emit read
    logic [CNT_W-1:0]    pos_m1;
    logic [DB-1:0]       emit_digit;

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_chr.valid      = r_out_valid;
    assign o_chr.character  = r_char;
    assign o_chr.char_valid = r_char_valid;
    assign o_chr.last       = r_last;

    // store address of the digit emitted from the next cycle on
    assign rd_addr = IDX_W'(n_pos - 1'b1);

    always_comb begin
        trial    = {r_rem, r_value[VALUE_BITS-1]};
        quo_bit  = (trial >= r_radix);
        rem_next = quo_bit ? DB'(trial - r_radix) : trial[DB-1:0];

        req_neg     = i_req.is_signed & i_req.number[VALUE_BITS-1];
        req_mag     = req_neg ? VALUE_BITS'(~i_req.number + 1'b1) : i_req.number;
        width_ext   = {1'b0, i_req.min_width};
        width_clamp = (width_ext > MAX_CLAMP) ? MAX_CLAMP : width_ext;

        pos_m1     = r_pos - 1'b1;
        // padding zeros above the significant digits
        emit_digit = (r_pos > r_count) ? '0 : r_emit_digit;
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_value      = r_value;
        n_rem        = r_rem;
        n_bit_cnt    = r_bit_cnt;
        n_count      = r_count;
        n_width      = r_width;
        n_pos        = r_pos;
        n_radix      = r_radix;
        n_sign       = r_sign;
        n_empty      = r_empty;
        n_char       = r_char;
        n_char_valid = r_char_valid;
        n_last       = r_last;
        store_we     = 1'b0;

        // receiver took the pending character
        if (r_out_valid && o_chr.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_value   = req_mag;
                    n_rem     = '0;
                    n_bit_cnt = '0;
                    n_count   = '0;
                    n_width   = CNT_W'(width_clamp);
                    n_sign    = req_neg;
                    n_empty   = (req_mag == '0) && (width_clamp == '0);
                    if (i_req.radix < rita_pkg::RADIX_MIN) begin
                        n_radix = rita_pkg::RADIX_MIN;
                    end else if (i_req.radix > rita_pkg::RADIX_MAX) begin
                        n_radix = rita_pkg::RADIX_MAX;
                    end else begin
                        n_radix = i_req.radix;
                    end
                    // zero magnitude has no significant digits, only padding
                    if (req_mag == '0) begin
                        n_pos   = CNT_W'(width_clamp);
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                n_value   = {r_value[VALUE_BITS-2:0], quo_bit};
                n_rem     = rem_next;
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == LAST_BIT) begin
                    // pass done: remainder is the next digit, value holds the quotient
                    n_bit_cnt = '0;
                    n_rem     = '0;
                    if (r_count < MAX_CNT) begin
                        store_we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                    if (n_value == '0) begin
                        n_pos   = (r_width > n_count) ? r_width : n_count;
                        n_state = ST_EMIT;
                    end
                end
            end

            ST_EMIT: begin
                if (!r_out_valid || o_chr.ready) begin
                    n_out_valid = 1'b1;
                    if (r_empty) begin
                        n_char       = rita_pkg::CHAR_NONE;
                        n_char_valid = 1'b0;
                        n_last       = 1'b1;
                        n_state      = ST_IDLE;
                    end else if (r_sign) begin
                        n_char       = rita_pkg::CHAR_MINUS;
                        n_char_valid = 1'b1;
                        n_last       = (r_pos == '0);
                        n_sign       = 1'b0;
                        if (r_pos == '0) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_char       = rita_pkg::digit_to_ascii(emit_digit);
                        n_char_valid = 1'b1;
                        n_last       = (r_pos == CNT_W'(1));
                        n_pos        = pos_m1;
                        if (r_pos == CNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_rem        <= n_rem;
        r_bit_cnt    <= n_bit_cnt;
        r_count      <= n_count;
        r_width      <= n_width;
        r_pos        <= n_pos;
        r_radix      <= n_radix;
        r_sign       <= n_sign;
        r_empty      <= n_empty;
        r_char       <= n_char;
        r_char_valid <= n_char_valid;
        r_last       <= n_last;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // digit store write, one digit per division pass, and registered read
    // of the digit at the next emit position, bypassing a same-cycle write
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_digit_store[r_count[IDX_W-1:0]] <= rem_next;
        end
        if (store_we && (rd_addr == r_count[IDX_W-1:0])) begin
            r_emit_digit <= rem_next;
        end else begin
            r_emit_digit <= r_digit_store[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/radix_integer_to_ascii_unit_tb.sv -----
// testbench of the radix integer to ascii unit: checks every character against its own prediction
module radix_integer_to_ascii_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_DIGITS     = 32;
    localparam int MAX_GAP        = 12;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 47;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [VALUE_BITS-1:0]                 number;
        logic                                  is_signed;
        logic [rita_pkg::RADIX_BITS-1:0]       radix;
        logic [rita_pkg::WIDTH_FIELD_BITS-1:0] min_width;
    } t_conv_req;

    typedef struct packed {
        logic [rita_pkg::CHAR_BITS-1:0] character;
        logic                           char_valid;
        logic                           last;
    } t_conv_char;

    // keeps the characters still owed by accepted requests, oldest first
    class t_char_scoreboard;
        t_conv_char owed_chars[$];
        int         mismatch_count = 0;

        function int pending();
            return owed_chars.size();
        endfunction

        function t_conv_char make_char(input logic [rita_pkg::CHAR_BITS-1:0] c,
                                       input logic lst);
            t_conv_char r;
            r.character  = c;
            r.char_valid = 1'b1;
            r.last       = lst;
            return r;
        endfunction

        // works out the character stream of one request
        function void note_request(input t_conv_req r);
            logic [rita_pkg::RADIX_BITS-1:0]       base;
            logic [rita_pkg::WIDTH_FIELD_BITS-1:0] width;
            logic                                  negative;
            logic [VALUE_BITS-1:0]                 magnitude;
            logic [rita_pkg::DIGIT_BITS-1:0]       digits [MAX_DIGITS];
            logic [rita_pkg::DIGIT_BITS-1:0]       d;
            logic [rita_pkg::CHAR_BITS-1:0]        c;
            int                                    n_digits;
            int                                    total;
            t_conv_char                            empty_char;

            base = r.radix;
            if (base < rita_pkg::RADIX_MIN) begin
                base = rita_pkg::RADIX_MIN;
            end
            if (base > rita_pkg::RADIX_MAX) begin
                base = rita_pkg::RADIX_MAX;
            end
            width = (r.min_width > MAX_DIGITS) ? rita_pkg::WIDTH_FIELD_BITS'(MAX_DIGITS)
                                               : r.min_width;

            negative  = r.is_signed && r.number[VALUE_BITS-1];
            magnitude = negative ? (~r.number + 1'b1) : r.number;

            // remainders come out least significant first
            n_digits = 0;
            while (magnitude != '0) begin
                if (n_digits < MAX_DIGITS) begin
                    digits[n_digits] = rita_pkg::DIGIT_BITS'(magnitude % base);
                    n_digits++;
                end
                magnitude = magnitude / base;
            end
            total = (int'(width) > n_digits) ? int'(width) : n_digits;

            // zero with no width asked: one empty marker
            if (!negative && total == 0) begin
                empty_char.character  = rita_pkg::CHAR_NONE;
                empty_char.char_valid = 1'b0;
                empty_char.last       = 1'b1;
                owed_chars.push_back(empty_char);
                return;
            end

            if (negative) begin
                owed_chars.push_back(make_char(rita_pkg::CHAR_MINUS, total == 0));
            end
            for (int j = total; j > 0; j--) begin
                d = (j > n_digits) ? '0 : digits[j-1];
                if (d < rita_pkg::DIGIT_TEN) begin
                    c = rita_pkg::CHAR_ZERO + rita_pkg::CHAR_BITS'(d);
                end else begin
                    c = rita_pkg::CHAR_A + rita_pkg::CHAR_BITS'(d - rita_pkg::DIGIT_TEN);
                end
                owed_chars.push_back(make_char(c, j == 1));
            end
        endfunction

        task report(input string msg);
            if (mismatch_count < PRINT_LIMIT) begin
                $display("[%0t] char check failed: %s", $realtime, msg);
            end
            mismatch_count++;
        endtask

        task check_char(input t_conv_char got);
            t_conv_char want;
            if (owed_chars.size() == 0) begin
                report($sformatf("unexpected char %h valid %b last %b",
                                 got.character, got.char_valid, got.last));
            end else begin
                want = owed_chars.pop_front();
                if (got.character !== want.character) begin
                    report($sformatf("character %h, wanted %h", got.character, want.character));
                end
                if (got.char_valid !== want.char_valid) begin
                    report($sformatf("char_valid %b, wanted %b", got.char_valid, want.char_valid));
                end
                if (got.last !== want.last) begin
                    report($sformatf("last %b, wanted %b", got.last, want.last));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rita_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
    rita_chr_if                            chr_bus ();

    radix_integer_to_ascii_unit #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_chr  (chr_bus)
    );

    always #5 i_clk = ~i_clk;

    t_char_scoreboard sb = new();

    // idling knobs, changed per phase
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit long_hold_rq = 1'b0;

    // both channels are sampled at the rising edge
    always @(posedge i_clk) begin
        t_conv_req  r;
        t_conv_char c;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                r.number    = req_bus.number;
                r.is_signed = req_bus.is_signed;
                r.radix     = req_bus.radix;
                r.min_width = req_bus.min_width;
                sb.note_request(r);
            end
            if (chr_bus.valid && chr_bus.ready) begin
                c.character  = chr_bus.character;
                c.char_valid = chr_bus.char_valid;
                c.last       = chr_bus.last;
                sb.check_char(c);
            end
        end
    end

    // ends the run when no request or char has moved for too long
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (chr_bus.valid && chr_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls per char, one long hold-off on request
    initial begin
        int gap;
        chr_bus.ready <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold_rq) begin
                long_hold_rq = 1'b0;
                chr_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                if (gap > 0) begin
                    chr_bus.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            chr_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!chr_bus.valid);
            @(negedge i_clk);
        end
    end

    // offers one request, returns at the falling edge after it is taken
    task send_request(input t_conv_req r);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.number    <= r.number;
        req_bus.is_signed <= r.is_signed;
        req_bus.radix     <= r.radix;
        req_bus.min_width <= r.min_width;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
    endtask

    // holds the sender until every owed char is out
    task wait_all_chars();
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function t_conv_req req_of(input logic [VALUE_BITS-1:0] num, input logic sgn,
                               input int base, input int width);
        t_conv_req r;
        r.number    = num;
        r.is_signed = sgn;
        r.radix     = rita_pkg::RADIX_BITS'(base);
        r.min_width = rita_pkg::WIDTH_FIELD_BITS'(width);
        return r;
    endfunction

    // mostly short numbers keep the serial divider quick
    function t_conv_req random_request();
        t_conv_req              r;
        logic [VALUE_BITS-1:0]  raw;
        int                     bits;
        raw  = $urandom;
        bits = $urandom_range(1, 14);
        case ($urandom_range(0, 7))
            0, 1: r.number = raw;
            2:    r.number = '0;
            3:    r.number = ~(raw & ((1 << bits) - 1));
            default: r.number = raw & ((1 << bits) - 1);
        endcase
        r.is_signed = 1'($urandom_range(0, 1));
        r.radix = ($urandom_range(0, 5) == 0)
                  ? rita_pkg::RADIX_BITS'($urandom_range(0, 31))
                  : rita_pkg::RADIX_BITS'($urandom_range(2, 16));
        r.min_width = ($urandom_range(0, 4) == 0)
                      ? rita_pkg::WIDTH_FIELD_BITS'($urandom_range(0, 63))
                      : rita_pkg::WIDTH_FIELD_BITS'($urandom_range(0, 10));
        return r;
    endfunction

    initial begin
        t_conv_req directed [$];

        req_bus.valid     <= 1'b0;
        req_bus.number    <= '0;
        req_bus.is_signed <= 1'b0;
        req_bus.radix     <= rita_pkg::RADIX_MIN;
        req_bus.min_width <= '0;
        i_rst_n           <= 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero with and without width, signed zero
        directed.push_back(req_of(32'h0000_0000, 1'b0, 10, 0));
        directed.push_back(req_of(32'h0000_0000, 1'b0, 10, 1));
        directed.push_back(req_of(32'h0000_0000, 1'b1, 16, 0));
        directed.push_back(req_of(32'h0000_0000, 1'b1, 2, 5));
        // all ones, unsigned and signed
        directed.push_back(req_of(32'hffff_ffff, 1'b0, 2, 0));
        directed.push_back(req_of(32'hffff_ffff, 1'b1, 10, 0));
        // most negative value printed in full, beside its unsigned reading and the largest positive value
        directed.push_back(req_of(32'h8000_0000, 1'b1, 2, 0));
        directed.push_back(req_of(32'h8000_0000, 1'b1, 10, 0));
        directed.push_back(req_of(32'h8000_0000, 1'b0, 10, 0));
        directed.push_back(req_of(32'h7fff_ffff, 1'b1, 16, 0));
        // bases outside 2..16 are clamped
        directed.push_back(req_of(32'd77, 1'b0, 0, 0));
        directed.push_back(req_of(32'd77, 1'b0, 1, 0));
        directed.push_back(req_of(32'hfedc_ba98, 1'b0, 17, 0));
        directed.push_back(req_of(32'hfedc_ba98, 1'b0, 31, 0));
        // padding and width clamping; the sign does not count toward the width
        directed.push_back(req_of(32'd12345, 1'b0, 3, 10));
        directed.push_back(req_of(-32'sd5, 1'b1, 8, 6));
        directed.push_back(req_of(32'h0000_00ff, 1'b0, 16, 32));
        directed.push_back(req_of(32'h0000_00ff, 1'b0, 16, 33));
        directed.push_back(req_of(32'h0000_0001, 1'b0, 16, 63));
        directed.push_back(req_of(32'hdead_beef, 1'b0, 16, 8));
        directed.push_back(req_of(32'd123456789, 1'b1, 7, 2));
        directed.push_back(req_of(32'h5555_5555, 1'b0, 4, 0));
        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        wait_all_chars();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
                1: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
                2: begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; long_hold_rq = 1'b1; end
                3: begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
                4: begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
                default: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_request(random_request());
            end
            wait_all_chars();
        end

        // let any stray char show up
        repeat (64) @(negedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rita_pkg.sv
rtl/core/rita_if.sv
rtl/core/radix_integer_to_ascii_unit.sv
tb/radix_integer_to_ascii_unit_tb.sv
